// File: design/bmp24_stream_encoder_unit_defines.svh
// Assertion helpers shared by the encoder RTL.
`ifndef BMP24_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BMP24_STREAM_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bmp24 encoder check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bmp24 encoder check failed");

`endif

// File: design/bmp24se_pkg.sv
`timescale 1ns / 1ps

package bmp24se_pkg;

	localparam int DIM_BITS_DEF = 13;
	localparam int CFG_W        = 14;
	localparam int IDX_W        = 6;

	// Byte positions within the run of one pixel word
	localparam logic [IDX_W-1:0] POS_MAGIC_B   = 6'd0;
	localparam logic [IDX_W-1:0] POS_MAGIC_M   = 6'd1;
	localparam logic [IDX_W-1:0] POS_WORDS     = 6'd2;
	localparam logic [IDX_W-1:0] POS_PLANES    = 6'd26;
	localparam logic [IDX_W-1:0] POS_BPP       = 6'd28;
	localparam logic [IDX_W-1:0] POS_PIX_THIRD = 6'd54;
	localparam logic [IDX_W-1:0] POS_PIX_SEC   = 6'd55;
	localparam logic [IDX_W-1:0] POS_PIX_FIRST = 6'd56;

	// Header word slots from POS_WORDS on, four bytes each
	localparam logic [2:0] WORD_SIZE   = 3'd0;
	localparam logic [2:0] WORD_RSVD   = 3'd1;
	localparam logic [2:0] WORD_OFFSET = 3'd2;
	localparam logic [2:0] WORD_INFO   = 3'd3;
	localparam logic [2:0] WORD_WIDTH  = 3'd4;
	localparam logic [2:0] WORD_HEIGHT = 3'd5;

	localparam logic [7:0]  CHAR_B      = 8'h42;
	localparam logic [7:0]  CHAR_M      = 8'h4D;
	localparam logic [7:0]  PLANES      = 8'd1;
	localparam logic [7:0]  BPP         = 8'd24;
	localparam logic [31:0] DATA_OFFSET = 32'd54;
	localparam logic [31:0] INFO_SIZE   = 32'd40;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 14'd720;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 14'd480;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

endpackage

// File: design/bmp24_stream_encoder_unit.sv
`timescale 1ns / 1ps
// An accepted pixel word is held in pix_s1, and each of its bytes then passes through the output register.
// Throughput: one output byte per cycle while m_axis_tready is high, from a single byte-wide output
// register, so a pixel gives 3 bytes, 57 on the first pixel of a frame (header) and 3 more at most
// for row padding; the next pixel is taken in the cycle its predecessor's last byte leaves.
// Reset (arst_n low, asynchronous): counters cleared, width 720, height 480, no word held.
`include "bmp24_stream_encoder_unit_defines.svh"

module bmp24_stream_encoder_unit #(
	parameter int DIM_BITS = bmp24se_pkg::DIM_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [0:0]                          cfg_index,
	input  logic [bmp24se_pkg::CFG_W-1:0]       cfg_data,
	// pixel input
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [23:0]                         s_axis_tdata,  // comp_first, comp_second, comp_third
	// file byte output
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [7:0]                          m_axis_tdata,  // out_byte
	output logic                                m_axis_tlast,
	output logic [0:0]                          m_axis_tuser   // end_of_image
);

	localparam int DW = DIM_BITS + 1;
	localparam int EW = (DW > bmp24se_pkg::CFG_W) ? DW : bmp24se_pkg::CFG_W;
	localparam int RW = DW + 2;
	localparam int PW = DW + RW;
	localparam logic [EW-1:0] CAP = {{(EW-1){1'b0}}, 1'b1} << DIM_BITS;

	function automatic logic [DW-1:0] eff_dim(input logic [bmp24se_pkg::CFG_W-1:0] v);
		logic [EW-1:0] ve;
		ve = EW'(v);
		if (ve == '0) begin
			eff_dim = DW'(1);
		end else if (ve > CAP) begin
			eff_dim = DW'(CAP);
		end else begin
			eff_dim = DW'(ve);
		end
	endfunction

	// configuration
	logic [bmp24se_pkg::CFG_W-1:0] width_q, height_q;

	// frame position
	logic [DIM_BITS-1:0] col_q, row_q;

	// word held for emission
	logic                          valid_s1;
	logic [bmp24se_pkg::IDX_W-1:0] idx_q;
	logic [23:0]                   pix_s1;
	logic [1:0]                    pad_s1;
	logic                          end_s1;
	logic [DW-1:0]                 w_s1, h_s1;
	logic [RW-1:0]                 rowb_s1;
	logic [31:0]                   size_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q, out_eoi_q;

	logic                          accept, out_free, emit, done, hdr;
	logic [DW-1:0]                 w_eff, h_eff, col_next, row_next;
	logic [1:0]                    pad_w;
	logic [RW-1:0]                 row_bytes;
	logic                          row_end, frame_end;
	logic [bmp24se_pkg::IDX_W-1:0] last_idx, rel;
	logic [PW-1:0]                 prod;
	logic [31:0]                   hdr_word;
	logic [7:0]                    byte_nxt;

	assign cfg_ready = 1'b1;

	assign w_eff     = eff_dim(width_q);
	assign h_eff     = eff_dim(height_q);
	assign pad_w     = 2'(2'd0 - w_eff[1:0]);
	assign row_bytes = RW'({w_eff, 1'b0}) + RW'(w_eff) + RW'(pad_w);
	assign col_next  = DW'(col_q) + DW'(1);
	assign row_next  = DW'(row_q) + DW'(1);
	assign row_end   = col_next >= w_eff;
	assign frame_end = row_end && (row_next >= h_eff);
	assign hdr       = (col_q == '0) && (row_q == '0);

	assign last_idx = bmp24se_pkg::POS_PIX_FIRST + bmp24se_pkg::IDX_W'(pad_s1);
	assign out_free = !out_valid_q || m_axis_tready;
	assign emit     = valid_s1 && out_free;
	assign done     = emit && (idx_q == last_idx);

	assign s_axis_tready = !valid_s1 || done;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign prod = PW'(h_s1) * PW'(rowb_s1);
	assign rel  = idx_q - bmp24se_pkg::POS_WORDS;

	always_comb begin
		case (rel[4:2])
			bmp24se_pkg::WORD_SIZE:   hdr_word = size_q;
			bmp24se_pkg::WORD_RSVD:   hdr_word = '0;
			bmp24se_pkg::WORD_OFFSET: hdr_word = bmp24se_pkg::DATA_OFFSET;
			bmp24se_pkg::WORD_INFO:   hdr_word = bmp24se_pkg::INFO_SIZE;
			bmp24se_pkg::WORD_WIDTH:  hdr_word = 32'(w_s1);
			bmp24se_pkg::WORD_HEIGHT: hdr_word = 32'd0 - 32'(h_s1);
			default:                  hdr_word = '0;
		endcase
	end

	always_comb begin
		if (idx_q == bmp24se_pkg::POS_MAGIC_B) begin
			byte_nxt = bmp24se_pkg::CHAR_B;
		end else if (idx_q == bmp24se_pkg::POS_MAGIC_M) begin
			byte_nxt = bmp24se_pkg::CHAR_M;
		end else if (idx_q < bmp24se_pkg::POS_PLANES) begin
			byte_nxt = 8'(hdr_word >> {rel[1:0], 3'b000});
		end else if (idx_q == bmp24se_pkg::POS_PLANES) begin
			byte_nxt = bmp24se_pkg::PLANES;
		end else if (idx_q == bmp24se_pkg::POS_BPP) begin
			byte_nxt = bmp24se_pkg::BPP;
		end else if (idx_q == bmp24se_pkg::POS_PIX_THIRD) begin
			byte_nxt = pix_s1[23:16];
		end else if (idx_q == bmp24se_pkg::POS_PIX_SEC) begin
			byte_nxt = pix_s1[15:8];
		end else if (idx_q == bmp24se_pkg::POS_PIX_FIRST) begin
			byte_nxt = pix_s1[7:0];
		end else begin
			byte_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmp24se_pkg::WIDTH_RESET;
			height_q <= bmp24se_pkg::HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (bmp24se_pkg::cfg_reg_t'(cfg_index))
				bmp24se_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				bmp24se_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			idx_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				idx_q    <= hdr ? bmp24se_pkg::POS_MAGIC_B : bmp24se_pkg::POS_PIX_THIRD;
				if (row_end) begin
					col_q <= '0;
					row_q <= frame_end ? '0 : DIM_BITS'(row_next);
				end else begin
					col_q <= DIM_BITS'(col_next);
				end
			end else if (done) begin
				valid_s1 <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + bmp24se_pkg::IDX_W'(1);
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= s_axis_tdata;
			pad_s1  <= row_end ? pad_w : 2'd0;
			end_s1  <= frame_end;
			w_s1    <= w_eff;
			h_s1    <= h_eff;
			rowb_s1 <= row_bytes;
		end
		// size settles while 'B' goes out, well before its first byte is needed
		if (valid_s1 && idx_q == bmp24se_pkg::POS_MAGIC_B) begin
			size_q <= 32'(prod) + bmp24se_pkg::DATA_OFFSET;
		end
		if (emit) begin
			out_byte_q <= byte_nxt;
			out_last_q <= idx_q == last_idx;
			out_eoi_q  <= (idx_q == last_idx) && end_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_eoi_q;

	`BSE_ASSERT_NOW(a_eoi_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
	`BSE_ASSERT_NOW(a_idx_bound, valid_s1, idx_q <= last_idx)
	`BSE_ASSERT_NOW(a_frame_wraps, done && end_s1, col_q == '0 && row_q == '0)
	`BSE_ASSERT_NEXT(a_hdr_start, accept && hdr, valid_s1 && idx_q == bmp24se_pkg::POS_MAGIC_B)

endmodule

// File: bench/bmp_stream_checker.sv
`timescale 1ns / 1ps

module bmp_stream_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [0:0]                    cfg_index,
	input  logic [bmp24se_pkg::CFG_W-1:0] cfg_data,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,   // comp_first, comp_second, comp_third
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [7:0]                    m_axis_tdata,   // out_byte
	input  logic                          m_axis_tlast,
	input  logic [0:0]                    m_axis_tuser,   // end_of_image
	output int                            errors,
	output int                            queued
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       eoi;
	} file_byte_t;

	file_byte_t                           file_bytes [$];
	logic [bmp24se_pkg::CFG_W-1:0]        width_reg;
	logic [bmp24se_pkg::CFG_W-1:0]        height_reg;
	logic [bmp24se_pkg::DIM_BITS_DEF-1:0] col_cnt;
	logic [bmp24se_pkg::DIM_BITS_DEF-1:0] row_cnt;
	int                                   bad_words;

	// zero counts as one, anything past the counter range is capped
	function automatic int unsigned used_dim(input logic [bmp24se_pkg::CFG_W-1:0] v);
		int unsigned cap;
		cap = 1 << bmp24se_pkg::DIM_BITS_DEF;
		if (v == '0)
			return 1;
		if (v > cap)
			return cap;
		return v;
	endfunction

	task automatic encode_pixel(input logic [23:0] px);
		int unsigned w;
		int unsigned h;
		int unsigned pad;
		logic [31:0] hdr [6];
		logic [7:0]  run [$];
		logic        frame_done;
		int          k;
		w = used_dim(width_reg);
		h = used_dim(height_reg);
		pad = (4 - (w & 3)) & 3;
		frame_done = 1'b0;
		if (col_cnt == '0 && row_cnt == '0) begin
			hdr[0] = 32'(54 + h * (3 * w + pad));
			hdr[1] = 32'd0;
			hdr[2] = bmp24se_pkg::DATA_OFFSET;
			hdr[3] = bmp24se_pkg::INFO_SIZE;
			hdr[4] = 32'(w);
			// negative height marks top-down row order
			hdr[5] = 32'd0 - 32'(h);
			run.push_back(bmp24se_pkg::CHAR_B);
			run.push_back(bmp24se_pkg::CHAR_M);
			for (k = 0; k < 24; k++)
				run.push_back(hdr[k / 4][8 * (k % 4) +: 8]);
			run.push_back(bmp24se_pkg::PLANES);
			run.push_back(8'd0);
			run.push_back(bmp24se_pkg::BPP);
			run.push_back(8'd0);
			for (k = 0; k < 24; k++)
				run.push_back(8'd0);
		end
		run.push_back(px[23:16]);
		run.push_back(px[15:8]);
		run.push_back(px[7:0]);
		if (col_cnt + 1 >= w) begin
			for (k = 0; k < pad; k++)
				run.push_back(8'd0);
			col_cnt = '0;
			if (row_cnt + 1 >= h) begin
				row_cnt = '0;
				frame_done = 1'b1;
			end else begin
				row_cnt = row_cnt + 1'b1;
			end
		end else begin
			col_cnt = col_cnt + 1'b1;
		end
		for (k = 0; k < run.size(); k++)
			file_bytes.push_back(file_byte_t'{run[k], k == run.size() - 1,
				(k == run.size() - 1) && frame_done});
	endtask

	always @(posedge clk or negedge arst_n) begin
		file_byte_t want;
		logic       bad;
		if (!arst_n) begin
			width_reg = bmp24se_pkg::WIDTH_RESET;
			height_reg = bmp24se_pkg::HEIGHT_RESET;
			col_cnt = '0;
			row_cnt = '0;
			bad_words = 0;
			file_bytes.delete();
			errors <= 0;
			queued <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				bad = 1'b0;
				want = '0;
				if (file_bytes.size() == 0) begin
					bad = 1'b1;
				end else begin
					want = file_bytes.pop_front();
					bad = (want.data !== m_axis_tdata) || (want.last !== m_axis_tlast) ||
						(want.eoi !== m_axis_tuser[0]);
				end
				if (bad) begin
					if (bad_words < 10) begin
						if (file_bytes.size() == 0 && want == '0 && m_axis_tdata !== 8'd0)
							$display("unexpected word: data %02h last %b eoi %b",
								m_axis_tdata, m_axis_tlast, m_axis_tuser);
						else
							$display("word mismatch: expected %02h/%b/%b got %02h/%b/%b",
								want.data, want.last, want.eoi,
								m_axis_tdata, m_axis_tlast, m_axis_tuser);
					end
					bad_words++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (bmp24se_pkg::cfg_reg_t'(cfg_index))
					bmp24se_pkg::REG_IMAGE_WIDTH:  width_reg = cfg_data;
					bmp24se_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				encode_pixel(s_axis_tdata);
			queued <= file_bytes.size();
			errors <= bad_words;
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_PIXELS = 420;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [0:0]                    cfg_index;
	logic [bmp24se_pkg::CFG_W-1:0] cfg_data;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [23:0]                   s_axis_tdata;   // comp_first, comp_second, comp_third
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [7:0]                    m_axis_tdata;   // out_byte
	logic                          m_axis_tlast;
	logic [0:0]                    m_axis_tuser;   // end_of_image
	int                            errors;
	int                            queued;

	logic                          gaps_on;
	int                            burst_left;
	int                            sent;

	bmp24_stream_encoder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	bmp_stream_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.queued        (queued)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	// receiver: pick a random stall pattern, hold it for a random span, then pick again
	initial begin
		int mode;
		int span;
		m_axis_tready <= 1'b0;
		mode = 0;
		span = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(16, 96);
			end
			span--;
			case (mode)
				0:       m_axis_tready <= 1'b1;
				1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
				2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= (span % 3 == 0);
			endcase
		end
	end

	task automatic write_reg(input bmp24se_pkg::cfg_reg_t idx,
		input logic [bmp24se_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic send_pixel(input logic [23:0] px);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	// drop valid, drain every expected word, then give the pipeline time to empty
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (queued != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [bmp24se_pkg::CFG_W-1:0] w,
		input logic [bmp24se_pkg::CFG_W-1:0] h);
		settle();
		write_reg(bmp24se_pkg::REG_IMAGE_WIDTH, w);
		write_reg(bmp24se_pkg::REG_IMAGE_HEIGHT, h);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [23:0] rand_pixel();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 24'h000000;
		if (r == 1)
			return 24'hFFFFFF;
		return 24'($urandom());
	endfunction

	// mostly small sizes so frames close often; now and then an extreme
	function automatic logic [bmp24se_pkg::CFG_W-1:0] rand_dim(input int small_max);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return bmp24se_pkg::CFG_W'($urandom_range(1, small_max));
		if (r < 78)
			return '0;
		if (r < 84)
			return bmp24se_pkg::CFG_W'(8192);
		if (r < 89)
			return '1;
		if (r < 95)
			return bmp24se_pkg::CFG_W'($urandom_range(8193, 16383));
		return bmp24se_pkg::CFG_W'($urandom());
	endfunction

	initial begin
		int n;
		int k;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= bmp24se_pkg::REG_IMAGE_WIDTH;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		gaps_on = 1'b0;
		burst_left = 0;
		sent = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// header from the reset sizes
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		// one-pixel frames, a header on every word
		reconfigure(14'd1, 14'd1);
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		send_pixel(24'hA5C30F);
		// padding of two, one and zero bytes
		reconfigure(14'd2, 14'd2);
		for (k = 0; k < 4; k++)
			send_pixel(rand_pixel());
		reconfigure(14'd3, 14'd1);
		for (k = 0; k < 3; k++)
			send_pixel(rand_pixel());
		reconfigure(14'd4, 14'd1);
		for (k = 0; k < 4; k++)
			send_pixel(rand_pixel());
		// zero sizes
		reconfigure(14'd0, 14'd0);
		send_pixel(24'h5A3CF0);
		send_pixel(24'h0FF00F);
		// oversized sizes, then shrink the row mid-frame and close the frame
		reconfigure(14'h3FFF, 14'd8193);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h000000);
		reconfigure(14'd2, 14'd8192);
		send_pixel(rand_pixel());
		reconfigure(14'd1, 14'd1);
		send_pixel(rand_pixel());
		send_pixel(rand_pixel());

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			reconfigure(rand_dim(9), rand_dim(4));
			gaps_on = ($urandom_range(0, 3) != 0);
			burst_left = 0;
			n = $urandom_range(1, 24);
			for (k = 0; k < n; k++)
				send_pixel(rand_pixel());
		end

		settle();
		repeat (16) @(posedge clk);
		if (errors == 0 && queued == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/bmp24se_pkg.sv
design/bmp24_stream_encoder_unit.sv
bench/bmp_stream_checker.sv
bench/testbench.sv
